// ----- rtl/core/rgt_pkg.sv -----
// ----------------------------------------------------------------------------
// rgt_pkg
// Shared types and codes for the receive gap tracker and retransmit-request
// scheduler.
// ----------------------------------------------------------------------------
package rgt_pkg;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_FIND,
		ST_TSCAN,
		ST_TUPD,
		ST_TOUT,
		ST_DONE
	} state_t;

	// Input word kinds.
	localparam logic REQ_PACKET = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// Result word kinds.
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Packet status codes.
	localparam logic [2:0] STS_IN_ORDER = 3'd0;
	localparam logic [2:0] STS_GAP      = 3'd1;
	localparam logic [2:0] STS_RESYNC   = 3'd2;
	localparam logic [2:0] STS_DUP      = 3'd3;
	localparam logic [2:0] STS_IGNORED  = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_PING  = 1'b0;
	localparam logic CFG_RETRY = 1'b1;

	// Register reset values.
	localparam logic [15:0] PING_RESET  = 16'd21;
	localparam logic [2:0]  RETRY_RESET = 3'd4;

	// Header checks and limits.
	localparam logic [15:0] MIN_DGRAM   = 16'h0010;
	localparam logic [7:0]  DATA_KIND   = 8'h00;
	localparam int          MAX_RESULTS = 32;
	localparam int          RB_AW       = 5;
	localparam int          NE_W        = 6;

	// Commands to the missing table.
	typedef struct packed {
		logic rd;
		logic wr;
		logic ins;
		logic del;
		logic clr;
	} tbl_cmd_t;

	// Status back from the missing table.
	typedef struct packed {
		logic rd_vld;
		logic full;
	} tbl_stat_t;

endpackage

// ----- rtl/core/rgt_miss_table.sv -----
// ----------------------------------------------------------------------------
// rgt_miss_table
// Missing-sequence table: one synchronous memory of key and retry count, a
// valid bit per entry, a live-entry count and a first-free-slot encoder.
// ----------------------------------------------------------------------------
module rgt_miss_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rgt_pkg::tbl_cmd_t cmd,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [15:0]       wr_key,
	input  logic [2:0]        wr_ret,
	output logic [15:0]       rd_key,
	output logic [2:0]        rd_ret,
	output rgt_pkg::tbl_stat_t stat,
	output logic [CW-1:0]     cnt
);
	import rgt_pkg::*;

	logic [18:0]   mem [DEPTH];
	logic [18:0]   rd_data_q;
	logic          rd_vld_q;
	logic [DEPTH-1:0] vld_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] free_idx;
	logic [AW-1:0] waddr;
	logic [18:0]   wdata;

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!vld_q[i]) begin
				free_idx = AW'(i);
			end
		end
	end

	// An insert goes to the free slot with a fresh retry count.
	assign waddr = cmd.ins ? free_idx : wr_addr;
	assign wdata = cmd.ins ? {wr_key, 3'd0} : {wr_key, wr_ret};

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr || cmd.ins) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Valid bits, the read entry's valid flag and the live count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd.rd) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (cmd.clr) begin
				vld_q <= '0;
				cnt_q <= '0;
			end else if (cmd.ins) begin
				vld_q[free_idx] <= 1'b1;
				cnt_q           <= cnt_q + CW'(1);
			end else if (cmd.del) begin
				vld_q[wr_addr] <= 1'b0;
				cnt_q          <= cnt_q - CW'(1);
			end
		end
	end

	assign rd_key      = rd_data_q[18:3];
	assign rd_ret      = rd_data_q[2:0];
	assign stat.rd_vld = rd_vld_q;
	assign stat.full   = &vld_q;
	assign cnt         = cnt_q;

endmodule

// ----- rtl/core/receive_gap_tracker_nak_scheduler.sv -----
// ----------------------------------------------------------------------------
// receive_gap_tracker_nak_scheduler
// Tracks the received sequence window, records skipped numbers in a missing
// table and walks that table on a timer tick to issue retransmit requests.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall  | header or timer tick
// out     | output    | out_valid/out_stall| packet status or request entry
// cfg     | input     | cfg_valid/cfg_ready| register index and data
//
// A filtered, first, resync or in-order header goes straight to its status word;
// an inside-window header first scans the table; a gap fill first records the
// skipped numbers in the table. An empty or flushing tick gives no word. Any
// other tick scans the table once per live entry in ascending order, plus a
// final scan, and then sends one request word per collected entry.
// Reset empties the window and the table at once. A stalled output holds the
// next word back; input stalls while an item is in work.
// ----------------------------------------------------------------------------
module receive_gap_tracker_nak_scheduler #(
	parameter int MAX_GAP    = 32,
	parameter int WINDOW     = 512,
	parameter int MISS_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [15:0] datagram_length,
	input  logic [15:0] header_length,
	input  logic [7:0]  packet_kind,
	input  logic [15:0] sequence_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [2:0]  status,
	output logic [15:0] request_sequence,
	output logic        single_request,
	output logic        last,
	output logic [6:0]  missing_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import rgt_pkg::*;

	localparam int AW = $clog2(MISS_DEPTH);
	localparam int CW = $clog2(MISS_DEPTH + 1);
	localparam logic [AW:0] SCAN_END = (AW + 1)'(MISS_DEPTH);

	state_t        state_q, state_d;
	logic [15:0]   ping_q;
	logic [2:0]    retry_q;
	logic [15:0]   win_low_q, win_high_q;
	logic          win_vld_q;
	logic          ovf_q;
	logic [AW:0]   scan_q;
	logic          first_q;
	logic          best_ok_q;
	logic [NE_W-1:0] ne_q;
	logic [RB_AW-1:0] k_q;
	logic          out_valid_q;

	logic [15:0]   seq_q;
	logic [15:0]   fill_q;
	logic [2:0]    status_q;
	logic [15:0]   prev_q;
	logic [15:0]   best_key_q;
	logic [2:0]    best_ret_q;
	logic [AW-1:0] best_idx_q;
	logic [15:0]   rbuf_q [MAX_RESULTS];

	logic          result_kind_q, single_q, last_q;
	logic [2:0]    status_out_q;
	logic [15:0]   req_seq_q;
	logic [6:0]    count_out_q;

	tbl_cmd_t      cmd;
	tbl_stat_t     tstat;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [15:0]   wr_key, rd_key;
	logic [2:0]    wr_ret, rd_ret;
	logic [CW-1:0] tcnt;

	logic          acc_in, out_free;
	logic          pkt_ign, pkt_resync, pkt_inside, pkt_jump;
	logic [16:0]   gap;
	logic          tk_empty, tk_flush;
	logic          scan_end, s1;
	logic [AW-1:0] idx_s1;
	logic          cand;
	logic          last_k;
	logic [15:0]   span;
	logic          drop_low;
	logic          load_stat, load_req;
	logic [6:0]    count_sat;

	rgt_miss_table #(
		.DEPTH (MISS_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_ret  (wr_ret),
		.rd_key  (rd_key),
		.rd_ret  (rd_ret),
		.stat    (tstat),
		.cnt     (tcnt)
	);

	// Handshakes.
	assign acc_in    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Header classification against the current window.
	assign gap        = {1'b0, sequence_req} - {1'b0, win_high_q};
	assign pkt_ign    = (datagram_length < MIN_DGRAM) || (packet_kind != DATA_KIND) ||
		(header_length == ping_q) || (sequence_req == 16'd0);
	assign pkt_resync = (sequence_req < win_low_q) ||
		((sequence_req > win_high_q) && (32'(gap) > 32'(MAX_GAP)));
	assign pkt_inside = (sequence_req <= win_high_q);
	assign pkt_jump   = (sequence_req > win_high_q) && (gap > 17'd1);

	// Tick screening.
	assign tk_empty = (tcnt == '0);
	assign tk_flush = (32'(tcnt) > 32'(MAX_GAP)) || ovf_q;

	// Window span; the lowest number drops once the span is full.
	assign span     = win_high_q - win_low_q;
	assign drop_low = (32'(span) + 32'd1) > 32'(WINDOW);

	// Table scan pipeline: address issued at scan_q, data back in the next cycle.
	assign scan_end = (scan_q == SCAN_END);
	assign s1       = (scan_q != '0);
	assign idx_s1   = AW'(scan_q - (AW + 1)'(1));
	assign cand     = s1 && tstat.rd_vld && (first_q || (rd_key > prev_q)) &&
		(!best_ok_q || (rd_key < best_key_q));

	assign last_k    = ((NE_W'(k_q) + NE_W'(1)) == ne_q);
	assign count_sat = (32'(tcnt) > 32'd127) ? 7'd127 : 7'(tcnt);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					if (req_type == REQ_PACKET) begin
						if (pkt_ign || !win_vld_q || pkt_resync) begin
							state_d = ST_DONE;
						end else if (pkt_inside) begin
							state_d = ST_FIND;
						end else if (pkt_jump) begin
							state_d = ST_FILL;
						end else begin
							state_d = ST_DONE;
						end
					end else if (!tk_empty && !tk_flush) begin
						state_d = ST_TSCAN;
					end
				end
			end
			ST_FILL: begin
				if (fill_q == seq_q) begin
					state_d = ST_DONE;
				end
			end
			ST_FIND: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_TSCAN: begin
				if (scan_end) begin
					state_d = ST_TUPD;
				end
			end
			ST_TUPD: begin
				if (best_ok_q) begin
					state_d = ST_TSCAN;
				end else if (ne_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_TOUT;
				end
			end
			ST_TOUT: begin
				if (out_free && last_k) begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table commands and output loads.
	always_comb begin
		cmd       = '0;
		rd_addr   = scan_q[AW-1:0];
		wr_addr   = best_idx_q;
		wr_key    = best_key_q;
		wr_ret    = best_ret_q + 3'd1;
		load_stat = 1'b0;
		load_req  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					if (req_type == REQ_PACKET) begin
						cmd.clr = !pkt_ign && win_vld_q && pkt_resync;
					end else begin
						cmd.clr = !tk_empty && tk_flush;
					end
				end
			end
			ST_FILL: begin
				wr_key  = fill_q;
				cmd.ins = (fill_q != seq_q) && !tstat.full;
			end
			ST_FIND: begin
				cmd.rd  = !scan_end;
				wr_addr = idx_s1;
				cmd.del = s1 && tstat.rd_vld && (rd_key == seq_q);
			end
			ST_TSCAN: begin
				cmd.rd = !scan_end;
			end
			ST_TUPD: begin
				if (best_ok_q && (best_key_q != 16'd0)) begin
					if (best_ret_q >= retry_q) begin
						cmd.del = 1'b1;
					end else if (32'(ne_q) < MAX_RESULTS) begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_TOUT: begin
				load_req = out_free;
			end
			ST_DONE: begin
				load_stat = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Control state, window and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ping_q      <= PING_RESET;
			retry_q     <= RETRY_RESET;
			win_low_q   <= '0;
			win_high_q  <= '0;
			win_vld_q   <= 1'b0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			first_q     <= 1'b1;
			best_ok_q   <= 1'b0;
			ne_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PING:  ping_q  <= cfg_data;
					CFG_RETRY: retry_q <= cfg_data[2:0];
					default:   ping_q  <= ping_q;
				endcase
			end
			// Output word register.
			if (load_stat || load_req) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					scan_q    <= '0;
					best_ok_q <= 1'b0;
					first_q   <= 1'b1;
					ne_q      <= '0;
					k_q       <= '0;
					if (acc_in && (req_type == REQ_PACKET) && !pkt_ign) begin
						if (!win_vld_q || pkt_resync) begin
							win_low_q  <= sequence_req;
							win_high_q <= sequence_req;
							win_vld_q  <= 1'b1;
							if (win_vld_q) begin
								ovf_q <= 1'b0;
							end
						end else if (!pkt_inside && !pkt_jump) begin
							if (drop_low) begin
								win_low_q <= win_low_q + 16'd1;
							end
							win_high_q <= sequence_req;
						end
					end
					if (acc_in && (req_type == REQ_TICK) && !tk_empty && tk_flush) begin
						win_low_q  <= '0;
						win_high_q <= '0;
						win_vld_q  <= 1'b0;
						ovf_q      <= 1'b0;
					end
				end
				ST_FILL: begin
					// One number appended per cycle.
					if (drop_low) begin
						win_low_q <= win_low_q + 16'd1;
					end
					win_high_q <= fill_q;
					if ((fill_q != seq_q) && tstat.full) begin
						ovf_q <= 1'b1;
					end
				end
				ST_FIND: begin
					if (!scan_end) begin
						scan_q <= scan_q + (AW + 1)'(1);
					end
				end
				ST_TSCAN: begin
					if (!scan_end) begin
						scan_q <= scan_q + (AW + 1)'(1);
					end
					if (cand) begin
						best_ok_q <= 1'b1;
					end
				end
				ST_TUPD: begin
					scan_q    <= '0;
					best_ok_q <= 1'b0;
					if (best_ok_q) begin
						first_q <= 1'b0;
						if (cmd.wr) begin
							ne_q <= ne_q + NE_W'(1);
						end
					end
				end
				ST_TOUT: begin
					if (out_free) begin
						k_q <= k_q + RB_AW'(1);
					end
				end
				default: begin
					scan_q <= scan_q;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			seq_q  <= sequence_req;
			fill_q <= win_high_q + 16'd1;
			if (pkt_ign) begin
				status_q <= STS_IGNORED;
			end else if (!win_vld_q) begin
				status_q <= STS_IN_ORDER;
			end else if (pkt_resync) begin
				status_q <= STS_RESYNC;
			end else if (pkt_inside) begin
				status_q <= STS_DUP;
			end else if (pkt_jump) begin
				status_q <= STS_GAP;
			end else begin
				status_q <= STS_IN_ORDER;
			end
		end
		if (state_q == ST_FILL) begin
			fill_q <= fill_q + 16'd1;
		end
		if ((state_q == ST_TSCAN) && cand) begin
			best_key_q <= rd_key;
			best_ret_q <= rd_ret;
			best_idx_q <= idx_s1;
		end
		if ((state_q == ST_TUPD) && best_ok_q) begin
			prev_q <= best_key_q;
		end
		if (cmd.wr) begin
			rbuf_q[ne_q[RB_AW-1:0]] <= best_key_q;
		end
		if (load_stat) begin
			result_kind_q <= KIND_STATUS;
			status_out_q  <= status_q;
			req_seq_q     <= 16'd0;
			single_q      <= 1'b0;
			last_q        <= 1'b1;
			count_out_q   <= count_sat;
		end else if (load_req) begin
			result_kind_q <= KIND_REQUEST;
			status_out_q  <= STS_IN_ORDER;
			req_seq_q     <= rbuf_q[k_q];
			single_q      <= (ne_q == NE_W'(1));
			last_q        <= last_k;
			count_out_q   <= count_sat;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = result_kind_q;
	assign status           = status_out_q;
	assign request_sequence = req_seq_q;
	assign single_request   = single_q;
	assign last             = last_q;
	assign missing_count    = count_out_q;

`ifndef SYNTHESIS
	// The window never inverts.
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		win_vld_q |-> (win_low_q <= win_high_q))
		else $error("window low above window high");

	// A tick after a table overflow empties the table.
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && (req_type == REQ_TICK) && ovf_q) |=> (tcnt == '0))
		else $error("table not empty after flush");

	// Request output only starts with words collected.
	a_tout_words: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOUT) |-> (ne_q != '0))
		else $error("request output with no words");

	// The request buffer never overfills.
	a_ne_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ne_q) <= MAX_RESULTS)
		else $error("request buffer overfilled");
`endif

endmodule
